// File: src/b64e_pkg.sv
package b64e_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] PadChar = 8'h3D;

  localparam logic [1:0] PhaseFirst  = 2'd0;
  localparam logic [1:0] PhaseSecond = 2'd1;
  localparam logic [1:0] PhaseThird  = 2'd2;

  // One byte's worth of characters: up to four, last_idx marks the last valid slot.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            eom;
  } b64e_entry_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [7:0] sym_to_char(input logic [5:0] sym);
    logic [7:0] v;
    begin
      v = {2'b00, sym};
      if (sym < 6'd26) begin
        sym_to_char = 8'h41 + v;
      end else if (sym < 6'd52) begin
        sym_to_char = 8'h61 + v - 8'd26;
      end else if (sym < 6'd62) begin
        sym_to_char = 8'h30 + v - 8'd52;
      end else if (sym == 6'd62) begin
        sym_to_char = 8'h2B;
      end else begin
        sym_to_char = 8'h2F;
      end
    end
  endfunction

endpackage

// File: src/b64e_front.sv
module b64e_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_message,
  output b64e_pkg::b64e_entry_t entry
);

  logic [3:0] leftover_r, leftover_nxt;
  logic [1:0] phase_r, phase_nxt;

  always_comb begin
    entry.chars    = {4{b64e_pkg::PadChar}};
    entry.last_idx = 2'd0;
    entry.eom      = end_of_message;
    leftover_nxt   = leftover_r;
    phase_nxt      = phase_r;
    unique case (phase_r)
      b64e_pkg::PhaseSecond: begin
        entry.chars[0] = b64e_pkg::sym_to_char({leftover_r[1:0], data_byte[7:4]});
        leftover_nxt   = data_byte[3:0];
        phase_nxt      = b64e_pkg::PhaseThird;
        if (end_of_message) begin
          entry.chars[1] = b64e_pkg::sym_to_char({data_byte[3:0], 2'b00});
          entry.last_idx = 2'd2;
        end
      end
      b64e_pkg::PhaseThird: begin
        entry.chars[0] = b64e_pkg::sym_to_char({leftover_r, data_byte[7:6]});
        entry.chars[1] = b64e_pkg::sym_to_char(data_byte[5:0]);
        entry.last_idx = 2'd1;
        leftover_nxt   = 4'd0;
        phase_nxt      = b64e_pkg::PhaseFirst;
      end
      default: begin
        entry.chars[0] = b64e_pkg::sym_to_char(data_byte[7:2]);
        leftover_nxt   = {2'b00, data_byte[1:0]};
        phase_nxt      = b64e_pkg::PhaseSecond;
        if (end_of_message) begin
          entry.chars[1] = b64e_pkg::sym_to_char({data_byte[1:0], 4'b0000});
          entry.last_idx = 2'd3;
        end
      end
    endcase
    if (end_of_message) begin
      leftover_nxt = 4'd0;
      phase_nxt    = b64e_pkg::PhaseFirst;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leftover_r <= 4'd0;
      phase_r    <= b64e_pkg::PhaseFirst;
    end else if (push) begin
      leftover_r <= leftover_nxt;
      phase_r    <= phase_nxt;
    end
  end

endmodule

// File: src/b64e_fifo.sv
module b64e_fifo #(
  parameter int unsigned DEPTH = b64e_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  b64e_pkg::b64e_entry_t push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output b64e_pkg::b64e_entry_t head_entry
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  b64e_pkg::b64e_entry_t mem [DEPTH];

  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign full       = (count_r == CntW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: src/b64e_back.sv
module b64e_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  b64e_pkg::b64e_entry_t head_entry,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_code_char,
  output logic                 out_final_char
);

  logic [1:0] idx_r;
  logic       valid_r;
  logic [7:0] char_r;
  logic       final_r;
  logic       load;
  logic       at_last;

  assign load    = head_valid && (!valid_r || !out_stall);
  assign at_last = (idx_r == head_entry.last_idx);
  assign pop     = load && at_last;

  assign out_valid      = valid_r;
  assign out_code_char  = char_r;
  assign out_final_char = final_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r   <= at_last ? 2'd0 : idx_r + 2'd1;
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r  <= head_entry.chars[idx_r];
      final_r <= head_entry.eom && at_last;
    end
  end

endmodule

// File: src/base64_stream_encoder_core.sv
// Base64 stream encoder, standard alphabet ('+', '/'), '=' padding. Bytes go
// in one per word with an end-of-message flag; characters come out one per
// word, the last one of a message flagged by out_final_char. A byte is taken
// and turned at once into its one to four characters, which wait in a short
// queue (QUEUE_DEPTH entries) while the output side sends them out at one
// character per cycle while out_stall is low. Sustained rate is therefore set
// by the output register: 4 characters per 3 bytes, one character for the
// first and second byte of a group, two for the third byte of a group, and up
// to four for a last byte. The first character of a byte is held in the queue
// and then in the output register. No configuration; no clearing after reset.
module base64_stream_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  // byte input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  // character output
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_code_char,
  output logic       out_final_char
);

  b64e_pkg::b64e_entry_t push_entry;
  b64e_pkg::b64e_entry_t head_entry;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic                  push;

  // front side stalls only on a full queue
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // classify the byte by group position, build its characters
  b64e_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .data_byte      (in_data_byte),
    .end_of_message (in_end_of_message),
    .entry          (push_entry)
  );

  // decouples byte intake from character output
  b64e_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  // serializes each entry, one character per word
  b64e_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (q_valid),
    .head_entry     (head_entry),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_char  (out_code_char),
    .out_final_char (out_final_char)
  );

endmodule
